// ===== hdl/mi3_pkg.sv =====
`default_nettype none

package mi3_pkg;

  // Q16.16 value of 1.0.
  localparam logic [31:0] OneQ16 = 32'h0001_0000;

  // Cofactor a*b - c*d of 32-bit entries, exact in 65 signed bits.
  localparam int CofW  = 65;
  // Determinant: three 32 x 65 products summed, exact in 97 signed bits.
  localparam int DetW  = 97;
  localparam int DMagW = 96;
  localparam int CMagW = 64;

  // Quotient bits resolved one per divider stage (bits 32 down to 0).
  localparam int DivSteps = 33;
  // Divider pipeline: setup stage, one stage per quotient bit, round, saturate.
  localparam int DivLat   = DivSteps + 3;

  typedef logic [3:0] mi3_idx_t;

  // Flattened entry order: m_00, m_01, m_02, m_10, ... m_22.
  // Cofactor k is m[CofA] * m[CofB] - m[CofC] * m[CofD].
  localparam mi3_idx_t CofA [9] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam mi3_idx_t CofB [9] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam mi3_idx_t CofC [9] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam mi3_idx_t CofD [9] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

  // Cofactors that multiply row 0 in the determinant expansion.
  localparam mi3_idx_t DetCof [3] = '{4'd0, 4'd3, 4'd6};

  // Per-beat side information that travels beside the data.
  typedef struct packed {
    logic valid;
    logic ident;
    logic affine;
    logic dzero;
  } mi3_flags_t;

endpackage

`default_nettype wire

// ===== hdl/mi3_div.sv =====
`default_nettype none

// Pipelined rounding divider: q = round(cmag * 2^32 / dmag), ties away from
// zero, signed by neg_i and saturated to 32-bit two's complement.
module mi3_div (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [mi3_pkg::CMagW-1:0]  cmag_i,
  input  wire logic [mi3_pkg::DMagW-1:0]  dmag_i,
  input  wire logic                       neg_i,
  output logic      [31:0]                q_o
);

  localparam int NW = mi3_pkg::CMagW + 32;
  localparam int SW = NW + mi3_pkg::DivSteps;

  logic [NW-1:0]                   r_q   [mi3_pkg::DivSteps+1];
  logic [mi3_pkg::DivSteps-1:0]    q_q   [mi3_pkg::DivSteps+1];
  logic [mi3_pkg::DMagW-1:0]       d_q   [mi3_pkg::DivSteps+1];
  logic                            neg_q [mi3_pkg::DivSteps+1];
  logic                            ovf_q [mi3_pkg::DivSteps+1];

  logic                            rnd_up;
  logic [mi3_pkg::DivSteps:0]      qr_q;
  logic                            rneg_q;
  logic                            rovf_q;
  logic [31:0]                     q_d;
  logic [31:0]                     sat_q;

  // The quotient reaches 2^33 exactly when cmag >= 2 * dmag.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= {cmag_i, 32'd0};
      q_q[0]   <= '0;
      d_q[0]   <= dmag_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= {33'd0, cmag_i} >= {dmag_i, 1'b0};
    end
  end

  for (genvar k = 0; k < mi3_pkg::DivSteps; k++) begin : g_step
    localparam int Sh = mi3_pkg::DivSteps - 1 - k;
    logic [SW-1:0] diff;
    assign diff = {{mi3_pkg::DivSteps{1'b0}}, r_q[k]}
                - ({{(SW-mi3_pkg::DMagW){1'b0}}, d_q[k]} << Sh);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k+1]   <= d_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
        if (!diff[SW-1]) begin
          r_q[k+1] <= diff[NW-1:0];
          q_q[k+1] <= q_q[k] | (mi3_pkg::DivSteps'(1) << Sh);
        end else begin
          r_q[k+1] <= r_q[k];
          q_q[k+1] <= q_q[k];
        end
      end
    end
  end

  // Round up when twice the remainder reaches the divisor.
  assign rnd_up = {r_q[mi3_pkg::DivSteps], 1'b0} >= {1'b0, d_q[mi3_pkg::DivSteps]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qr_q   <= {1'b0, q_q[mi3_pkg::DivSteps]} + {{mi3_pkg::DivSteps{1'b0}}, rnd_up};
      rneg_q <= neg_q[mi3_pkg::DivSteps];
      rovf_q <= ovf_q[mi3_pkg::DivSteps];
    end
  end

  always_comb begin
    if (!rneg_q) begin
      if (rovf_q || qr_q > (mi3_pkg::DivSteps+1)'(32'h7FFF_FFFF)) begin
        q_d = 32'h7FFF_FFFF;
      end else begin
        q_d = qr_q[31:0];
      end
    end else begin
      if (rovf_q || qr_q > (mi3_pkg::DivSteps+1)'(32'h8000_0000)) begin
        q_d = 32'h8000_0000;
      end else begin
        q_d = 32'd0 - qr_q[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q <= q_d;
    end
  end

  assign q_o = sat_q;

endmodule

`default_nettype wire

// ===== hdl/matrix_inverse_3x3_core.sv =====
`default_nettype none

// Inverse of a 3x3 signed Q16.16 matrix as adjugate over determinant. One
// matrix is taken per cycle while the output is not stalled: six stages
// form the cofactors (one 32x32 multiply per product), the determinant
// (32x33 partial products, recombined, summed) and the magnitudes, then
// nine pipelined restoring dividers spend 36 stages each (a setup stage,
// one quotient bit per stage, then rounding and saturation), and a final
// register applies the special cases. Every entry is the exact quotient
// rounded to nearest, ties away from zero, and saturated to 32 bits. A set
// use_identity returns the identity; a zero determinant clears invertible
// and zeroes all entries; a bottom row of exactly (0, 0, 1.0) forces the
// result's bottom row to (0, 0, 1.0); earlier cases take priority. The
// pipeline advances as one and holds while a finished beat sits stalled at
// the output, so no beat is lost or repeated.
module matrix_inverse_3x3_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        use_identity_i,
  input  wire logic [31:0] m_00_i,
  input  wire logic [31:0] m_01_i,
  input  wire logic [31:0] m_02_i,
  input  wire logic [31:0] m_10_i,
  input  wire logic [31:0] m_11_i,
  input  wire logic [31:0] m_12_i,
  input  wire logic [31:0] m_20_i,
  input  wire logic [31:0] m_21_i,
  input  wire logic [31:0] m_22_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             invertible_o,
  output logic      [31:0] inv_00_o,
  output logic      [31:0] inv_01_o,
  output logic      [31:0] inv_02_o,
  output logic      [31:0] inv_10_o,
  output logic      [31:0] inv_11_o,
  output logic      [31:0] inv_12_o,
  output logic      [31:0] inv_20_o,
  output logic      [31:0] inv_21_o,
  output logic      [31:0] inv_22_o
);

  localparam int CofW  = mi3_pkg::CofW;
  localparam int DetW  = mi3_pkg::DetW;

  // The pipeline moves whenever the output register can take a new beat.
  logic en;
  logic out_valid_q;
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;

  logic signed [31:0] m_in [9];
  assign m_in[0] = m_00_i;
  assign m_in[1] = m_01_i;
  assign m_in[2] = m_02_i;
  assign m_in[3] = m_10_i;
  assign m_in[4] = m_11_i;
  assign m_in[5] = m_12_i;
  assign m_in[6] = m_20_i;
  assign m_in[7] = m_21_i;
  assign m_in[8] = m_22_i;

  mi3_pkg::mi3_flags_t fl_d;
  assign fl_d.valid  = in_valid_i;
  assign fl_d.ident  = use_identity_i;
  assign fl_d.affine = (m_20_i == 32'd0) && (m_21_i == 32'd0) && (m_22_i == mi3_pkg::OneQ16);
  assign fl_d.dzero  = 1'b0;

  mi3_pkg::mi3_flags_t fl1_q, fl2_q, fl3_q, fl4_q, fl5_q, fl6_q;
  mi3_pkg::mi3_flags_t fl_dl_q [mi3_pkg::DivLat];
  mi3_pkg::mi3_flags_t fl6_d;

  // Stage 1: the eighteen entry products.
  logic signed [63:0] pa_q [9];
  logic signed [63:0] pb_q [9];
  logic signed [31:0] row0_s1_q [3];
  // Stage 2: cofactors.
  logic signed [CofW-1:0] cof2_q [9];
  logic signed [31:0]     row0_s2_q [3];
  // Stage 3: determinant partial products; cofactors carried.
  logic signed [CofW-1:0] lo3_q [3];
  logic signed [CofW-1:0] hi3_q [3];
  logic signed [CofW-1:0] cof3_q [9];
  // Stage 4: determinant terms.
  logic signed [DetW-1:0] term4_q [3];
  logic signed [CofW-1:0] cof4_q [9];
  // Stage 5: determinant.
  logic signed [DetW-1:0] det5_q;
  logic signed [CofW-1:0] cof5_q [9];
  // Stage 6: magnitudes and signs.
  logic signed [DetW-1:0]         det_neg;
  logic [mi3_pkg::DMagW-1:0]      dmag6_q;
  logic                           dneg6_q;
  logic [mi3_pkg::CMagW-1:0]      cmag6_q [9];
  logic                           cneg6_q [9];
  logic [31:0]                    q_div [9];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        pa_q[k]   <= m_in[mi3_pkg::CofA[k]] * m_in[mi3_pkg::CofB[k]];
        pb_q[k]   <= m_in[mi3_pkg::CofC[k]] * m_in[mi3_pkg::CofD[k]];
        cof2_q[k] <= CofW'(pa_q[k]) - CofW'(pb_q[k]);
        cof3_q[k] <= cof2_q[k];
        cof4_q[k] <= cof3_q[k];
        cof5_q[k] <= cof4_q[k];
      end
      for (int j = 0; j < 3; j++) begin
        row0_s1_q[j] <= m_in[j];
        row0_s2_q[j] <= row0_s1_q[j];
        // Split the cofactor into an unsigned low word and a signed high part.
        lo3_q[j] <= row0_s2_q[j]
                  * $signed({1'b0, cof2_q[mi3_pkg::DetCof[j]][31:0]});
        hi3_q[j] <= row0_s2_q[j]
                  * $signed(cof2_q[mi3_pkg::DetCof[j]][CofW-1:32]);
        term4_q[j] <= (DetW'(hi3_q[j]) <<< 32) + DetW'(lo3_q[j]);
      end
      det5_q <= term4_q[0] + term4_q[1] + term4_q[2];
    end
  end

  assign det_neg = -det5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dneg6_q <= det5_q[DetW-1];
      dmag6_q <= det5_q[DetW-1] ? det_neg[mi3_pkg::DMagW-1:0]
                                : det5_q[mi3_pkg::DMagW-1:0];
      for (int k = 0; k < 9; k++) begin
        cneg6_q[k] <= cof5_q[k][CofW-1];
        cmag6_q[k] <= cof5_q[k][CofW-1] ? mi3_pkg::CMagW'(-cof5_q[k])
                                        : mi3_pkg::CMagW'(cof5_q[k]);
      end
    end
  end

  always_comb begin
    fl6_d       = fl5_q;
    fl6_d.dzero = (det5_q == '0);
  end

  // Side information keeps step with the data, including through the dividers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl1_q <= '0;
      fl2_q <= '0;
      fl3_q <= '0;
      fl4_q <= '0;
      fl5_q <= '0;
      fl6_q <= '0;
      for (int s = 0; s < mi3_pkg::DivLat; s++) begin
        fl_dl_q[s] <= '0;
      end
    end else if (en) begin
      fl1_q <= fl_d;
      fl2_q <= fl1_q;
      fl3_q <= fl2_q;
      fl4_q <= fl3_q;
      fl5_q <= fl4_q;
      fl6_q <= fl6_d;
      fl_dl_q[0] <= fl6_q;
      for (int s = 1; s < mi3_pkg::DivLat; s++) begin
        fl_dl_q[s] <= fl_dl_q[s-1];
      end
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_div
    mi3_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .cmag_i (cmag6_q[k]),
      .dmag_i (dmag6_q),
      .neg_i  (cneg6_q[k] ^ dneg6_q),
      .q_o    (q_div[k])
    );
  end

  // Output stage: identity request, singular matrix and affine bottom row.
  mi3_pkg::mi3_flags_t fl_out;
  logic [31:0] res_d [9];
  logic [31:0] res_q [9];
  logic        invertible_d;
  logic        invertible_q;

  assign fl_out = fl_dl_q[mi3_pkg::DivLat-1];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      res_d[k] = q_div[k];
    end
    invertible_d = 1'b1;
    priority if (fl_out.ident) begin
      for (int k = 0; k < 9; k++) begin
        res_d[k] = (k == 0 || k == 4 || k == 8) ? mi3_pkg::OneQ16 : 32'd0;
      end
    end else if (fl_out.dzero) begin
      invertible_d = 1'b0;
      for (int k = 0; k < 9; k++) begin
        res_d[k] = 32'd0;
      end
    end else if (fl_out.affine) begin
      res_d[6] = 32'd0;
      res_d[7] = 32'd0;
      res_d[8] = mi3_pkg::OneQ16;
    end else begin
      invertible_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fl_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      invertible_q <= invertible_d;
      for (int k = 0; k < 9; k++) begin
        res_q[k] <= res_d[k];
      end
    end
  end

  assign invertible_o = invertible_q;
  assign inv_00_o = res_q[0];
  assign inv_01_o = res_q[1];
  assign inv_02_o = res_q[2];
  assign inv_10_o = res_q[3];
  assign inv_11_o = res_q[4];
  assign inv_12_o = res_q[5];
  assign inv_20_o = res_q[6];
  assign inv_21_o = res_q[7];
  assign inv_22_o = res_q[8];

endmodule

`default_nettype wire
